// ===== rtl/cbba_pkg.sv =====
// Shared types, constants and the controller state encoding for the chained block
// bump allocator. No dependencies; every other file in rtl imports it.
`timescale 1ns / 1ps
`default_nettype none

package cbba_pkg;

   localparam int MAX_BLOCKS_DEF = 16;
   localparam int ARENA_BYTES    = 4096;
   localparam int HEADER_BYTES   = 4;
   localparam int ADDR_W         = 12;
   localparam int PTR_W          = 13;
   localparam int ORPH_W         = 16;
   localparam int OP_W           = 3;
   localparam int STAT_W         = 2;

   localparam logic [PTR_W-1:0] DEFAULT_BLOCK_RESET = PTR_W'(1024);

   localparam logic [OP_W-1:0] OP_ALLOC         = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE          = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_KEEP    = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_RELEASE = 3'd3;
   localparam logic [OP_W-1:0] OP_CREATE        = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 2'd1;
   localparam logic [STAT_W-1:0] ST_ARENA_FULL = 2'd2;
   localparam logic [STAT_W-1:0] ST_SLOTS_FULL = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] request_bytes;
      logic [ADDR_W-1:0] address;
      logic              null_pointer;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [PTR_W-1:0]  bump;
      logic [PTR_W-1:0]  lim;
      logic [ORPH_W-1:0] orph;
   } rec_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } fin_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_CHK,
      S_CARVE,
      S_F_CHK,
      S_F_HDR,
      S_C_WR,
      S_CREATE,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/chained_block_bump_allocator_unit.sv =====
// Top level of the chained block bump allocator: config register, result register.
// Depends on cbba_pkg and instantiates cbba_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// The unit serves one beat at a time and returns exactly one result per beat.
// An allocate walks the block records newest to oldest, one record per cycle,
// and carves a new block if none has room. A free walks oldest to newest and
// then reads the size header. A clear walks every record. A finished result
// sits in an output register, so a new beat is taken while the previous
// result still waits. No clearing pass is needed after reset.
module chained_block_bump_allocator_unit #(
   parameter int MAX_BLOCKS = cbba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire cbba_pkg::req_type          req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output cbba_pkg::rsp_type               rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [cbba_pkg::PTR_W-1:0] csr_wr_data
);
   import cbba_pkg::*;

   logic [PTR_W-1:0] default_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             busy;
   logic             fin_ready;
   fin_type          fin;

   cbba_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_valid && !req_stall),
      .req           (req_data),
      .default_bytes (default_ff),
      .fin_ready     (fin_ready),
      .busy          (busy),
      .fin           (fin)
   );

   assign req_stall = busy;
   assign fin_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (fin.valid && fin_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = fin.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff   <= DEFAULT_BLOCK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            default_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/cbba_blk_mem.sv =====
// Block record memory: one record per chained block, synchronous read.
// Depends on cbba_pkg for the record type.
`timescale 1ns / 1ps
`default_nettype none

module cbba_blk_mem #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IW-1:0]    wr_idx,
   input  wire cbba_pkg::rec_type wr_data,
   input  wire logic [IW-1:0]    rd_idx,
   output cbba_pkg::rec_type     rd_data
);
   import cbba_pkg::*;

   rec_type mem [DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/cbba_hdr_mem.sv =====
// Header size store: one size per arena byte address, synchronous read.
// Depends on cbba_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module cbba_hdr_mem (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [cbba_pkg::ADDR_W-1:0]  wr_addr,
   input  wire logic [cbba_pkg::PTR_W-1:0]   wr_data,
   input  wire logic [cbba_pkg::ADDR_W-1:0]  rd_addr,
   output logic [cbba_pkg::PTR_W-1:0]        rd_data
);
   import cbba_pkg::*;

   logic [PTR_W-1:0] mem [ARENA_BYTES];
   logic [PTR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/cbba_ctrl.sv =====
// Allocator sequencer: walks block records, carves blocks, updates headers.
// Depends on cbba_pkg and instantiates cbba_blk_mem and cbba_hdr_mem.
`timescale 1ns / 1ps
`default_nettype none

module cbba_ctrl #(
   parameter int MAX_BLOCKS = cbba_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire cbba_pkg::req_type          req,
   input  wire logic [cbba_pkg::PTR_W-1:0] default_bytes,
   input  wire logic                       fin_ready,
   output logic                            busy,
   output cbba_pkg::fin_type               fin
);
   import cbba_pkg::*;

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   state_type         state_ff, state_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [PTR_W-1:0]  top_ff, top_in;
   req_type           req_ff, req_in;
   rec_type           rec_ff, rec_in;
   logic [ADDR_W-1:0] res_ff, res_in;
   logic [STAT_W-1:0] stat_ff, stat_in;

   logic              blk_we;
   logic [IW-1:0]     blk_widx;
   rec_type           blk_wdata;
   rec_type           blk_rdata;
   logic              hdr_we;
   logic [ADDR_W-1:0] hdr_waddr;
   logic [PTR_W-1:0]  hdr_wdata;
   logic [ADDR_W-1:0] hdr_raddr;
   logic [PTR_W-1:0]  hdr_rdata;

   logic [PTR_W-1:0]  need;
   logic [PTR_W-1:0]  carve_size;
   logic              room;
   logic              slots_full;
   logic              arena_over;
   logic              in_blk;
   logic              idx_last;
   logic              is_tail;
   logic [ORPH_W:0]   orph_sum;
   logic [ORPH_W-1:0] orph_new;
   logic [PTR_W-1:0]  blk_size;

   cbba_blk_mem #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_blk_mem (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_idx  (blk_widx),
      .wr_data (blk_wdata),
      .rd_idx  (idx_in),
      .rd_data (blk_rdata)
   );

   cbba_hdr_mem u_hdr_mem (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (hdr_waddr),
      .wr_data (hdr_wdata),
      .rd_addr (hdr_raddr),
      .rd_data (hdr_rdata)
   );

   // The record memory is read every cycle at idx_in, so blk_rdata holds the
   // record for idx_ff in the same cycle.
   assign need       = {1'b0, req_ff.request_bytes} + PTR_W'(HEADER_BYTES);
   assign carve_size = (default_bytes > need) ? default_bytes : need;
   assign room       = (blk_rdata.bump <= blk_rdata.lim)
                       && ((blk_rdata.lim - blk_rdata.bump) >= need);
   assign slots_full = (count_ff >= CW'(MAX_BLOCKS));
   assign arena_over = (({1'b0, top_ff} + {1'b0, carve_size}) > (PTR_W+1)'(ARENA_BYTES));
   assign in_blk     = ({1'b0, req_ff.address} >= {1'b0, blk_rdata.base})
                       && ({1'b0, req_ff.address} < blk_rdata.lim);
   assign idx_last   = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign hdr_raddr  = req_ff.address - ADDR_W'(HEADER_BYTES);
   assign is_tail    = (({2'b0, req_ff.address} + {1'b0, hdr_rdata})
                       == ({1'b0, rec_ff.bump} + (PTR_W+1)'(HEADER_BYTES)));
   assign orph_sum   = {1'b0, rec_ff.orph} + (ORPH_W+1)'(hdr_rdata);
   assign orph_new   = is_tail ? rec_ff.orph
                       : (orph_sum[ORPH_W] ? {ORPH_W{1'b1}} : orph_sum[ORPH_W-1:0]);
   assign blk_size   = rec_ff.lim - {1'b0, rec_ff.base};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
      end
      idx_ff  <= idx_in;
      req_ff  <= req_in;
      rec_ff  <= rec_in;
      res_ff  <= res_in;
      stat_ff <= stat_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority case (req.op)
                  OP_ALLOC:         state_in = (count_ff == '0) ? S_CARVE : S_A_CHK;
                  OP_FREE:          state_in = (req.null_pointer || count_ff == '0)
                                               ? S_DONE : S_F_CHK;
                  OP_CLEAR_KEEP,
                  OP_CLEAR_RELEASE: state_in = (count_ff == '0) ? S_DONE : S_C_WR;
                  OP_CREATE:        state_in = S_CREATE;
                  default:          state_in = S_DONE;
               endcase
            end
         end
         S_A_CHK: begin
            if (room) begin
               state_in = S_DONE;
            end else if (idx_ff == '0) begin
               state_in = S_CARVE;
            end
         end
         S_CARVE:  state_in = S_DONE;
         S_F_CHK: begin
            if (in_blk) begin
               state_in = S_F_HDR;
            end else if (idx_last) begin
               state_in = S_DONE;
            end
         end
         S_F_HDR:  state_in = S_DONE;
         S_C_WR: begin
            if (idx_last) begin
               state_in = S_DONE;
            end
         end
         S_CREATE: state_in = S_DONE;
         S_DONE: begin
            if (fin_ready) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      count_in  = count_ff;
      top_in    = top_ff;
      req_in    = req_ff;
      rec_in    = rec_ff;
      res_in    = res_ff;
      stat_in   = stat_ff;
      blk_we    = 1'b0;
      blk_widx  = idx_ff;
      blk_wdata = blk_rdata;
      hdr_we    = 1'b0;
      hdr_waddr = blk_rdata.bump[ADDR_W-1:0];
      hdr_wdata = need;
      fin.valid = 1'b0;
      fin.rsp   = '{result_address: res_ff, status: stat_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in  = req;
               res_in  = '0;
               stat_in = ST_OK;
               if (req.op == OP_ALLOC) begin
                  idx_in = IW'(count_ff - CW'(1));
               end else if (req.op == OP_FREE) begin
                  idx_in = '0;
                  if (!req.null_pointer && count_ff == '0) begin
                     stat_in = ST_NOT_FOUND;
                  end
               end else begin
                  idx_in = '0;
                  if (req.op == OP_CLEAR_RELEASE && count_ff == '0) begin
                     top_in = '0;
                  end
               end
            end
         end
         S_A_CHK: begin
            if (room) begin
               blk_we         = 1'b1;
               blk_wdata.bump = blk_rdata.bump + need;
               hdr_we         = 1'b1;
               res_in         = ADDR_W'(blk_rdata.bump + PTR_W'(HEADER_BYTES));
            end else if (idx_ff != '0) begin
               idx_in = idx_ff - IW'(1);
            end
         end
         S_CARVE: begin
            if (slots_full) begin
               stat_in = ST_SLOTS_FULL;
            end else if (arena_over) begin
               stat_in = ST_ARENA_FULL;
            end else begin
               blk_we    = 1'b1;
               blk_widx  = IW'(count_ff);
               blk_wdata = '{base: top_ff[ADDR_W-1:0], bump: top_ff + need,
                             lim: top_ff + carve_size, orph: '0};
               hdr_we    = 1'b1;
               hdr_waddr = top_ff[ADDR_W-1:0];
               res_in    = ADDR_W'(top_ff + PTR_W'(HEADER_BYTES));
               count_in  = count_ff + CW'(1);
               top_in    = top_ff + carve_size;
            end
         end
         S_F_CHK: begin
            if (in_blk) begin
               rec_in = blk_rdata;
            end else if (idx_last) begin
               stat_in = ST_NOT_FOUND;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_F_HDR: begin
            blk_we    = 1'b1;
            blk_wdata = rec_ff;
            blk_wdata.orph = orph_new;
            if (is_tail) begin
               blk_wdata.bump = {1'b0, req_ff.address} - PTR_W'(HEADER_BYTES);
            end
            // A fully orphaned block starts over from its base.
            if (orph_new == ORPH_W'(blk_size)) begin
               blk_wdata.bump = {1'b0, rec_ff.base};
            end
         end
         S_C_WR: begin
            blk_we         = 1'b1;
            blk_wdata.bump = {1'b0, blk_rdata.base};
            blk_wdata.orph = ORPH_W'(blk_rdata.lim - {1'b0, blk_rdata.base});
            if (idx_last) begin
               if (req_ff.op == OP_CLEAR_RELEASE) begin
                  count_in = '0;
                  top_in   = '0;
               end
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_CREATE: begin
            count_in = '0;
            top_in   = '0;
            if (default_bytes > PTR_W'(ARENA_BYTES)) begin
               stat_in = ST_ARENA_FULL;
            end else begin
               blk_we    = 1'b1;
               blk_widx  = '0;
               blk_wdata = '{base: '0, bump: '0, lim: default_bytes, orph: '0};
               count_in  = CW'(1);
               top_in    = default_bytes;
            end
         end
         S_DONE: begin
            fin.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_BLOCKS))
      else $error("block count above slot limit");

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, top_ff} <= (PTR_W+1)'(ARENA_BYTES))
      else $error("arena top beyond arena");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept && !busy |=> busy)
      else $error("accepted beat did not start work");

   a_hdr_write_alloc: assert property (@(posedge clock) disable iff (reset)
      hdr_we |-> req_ff.op == OP_ALLOC && blk_we)
      else $error("header written outside an allocate");

endmodule

`default_nettype wire
